>>> sv/sorted_deadline_timeout_queue_unit_defines.svh
// Assertion macros shared by the checker of the sorted deadline timeout queue.
`ifndef SORTED_DEADLINE_TIMEOUT_QUEUE_UNIT_DEFINES_SVH
`define SORTED_DEADLINE_TIMEOUT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SDTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sdtq_pkg.sv
// Shared types and constants of the sorted deadline timeout queue.
`timescale 1ns / 1ps
package sdtq_pkg;

    localparam int TASK_W = 4;
    localparam int WAKE_W = 32;
    localparam int OUT_DATA_W = 40;

    localparam logic ACTION_SET  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    typedef struct packed {
        logic              accepted;
        logic              expired_valid;
        logic [TASK_W-1:0] expired_task;
        logic              reschedule;
        logic              wake_armed;
        logic [WAKE_W-1:0] next_wake;
        logic              last;
    } t_result;

endpackage

>>> sv/sdtq_front.sv
// Front end: unpacks and classifies input transfers into a two-entry queue.
`timescale 1ns / 1ps
module sdtq_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [sdtq_pkg::TASK_W-1:0] i_task,
    input  logic [TIME_BITS-1:0]        i_deadline,
    input  logic [TIME_BITS-1:0]        i_now,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_tick,
    output logic                        o_reject,
    output logic [sdtq_pkg::TASK_W-1:0] o_task,
    output logic [TIME_BITS-1:0]        o_deadline,
    output logic [TIME_BITS-1:0]        o_now
);

    logic                        r_tick [2];
    logic                        r_rej  [2];
    logic [sdtq_pkg::TASK_W-1:0] r_task [2];
    logic [TIME_BITS-1:0]        r_dl   [2];
    logic [TIME_BITS-1:0]        r_now  [2];
    logic                        r_wptr, r_rptr;
    logic [1:0]                  r_cnt;
    logic [TIME_BITS-1:0]        w_diff;
    logic                        w_push, w_pop;

    // A set is refused unless now lies strictly before the deadline.
    assign w_diff  = i_now - i_deadline;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    assign o_tick     = r_tick[r_rptr];
    assign o_reject   = r_rej[r_rptr];
    assign o_task     = r_task[r_rptr];
    assign o_deadline = r_dl[r_rptr];
    assign o_now      = r_now[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_tick[r_wptr] <= (i_action == sdtq_pkg::ACTION_TICK);
            r_rej[r_wptr]  <= !w_diff[TIME_BITS-1];
            r_task[r_wptr] <= i_task;
            r_dl[r_wptr]   <= i_deadline;
            r_now[r_wptr]  <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= ~r_wptr;
            if (w_pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> sv/sdtq_back.sv
// Back end: sequencer over the sorted entry memory, producing result transfers.
`timescale 1ns / 1ps
module sdtq_back #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_tick,
    input  logic                        i_reject,
    input  logic [sdtq_pkg::TASK_W-1:0] i_task,
    input  logic [TIME_BITS-1:0]        i_deadline,
    input  logic [TIME_BITS-1:0]        i_now,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sdtq_pkg::t_result           o_result
);

    localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_F_RD, S_F_CMP, S_CHK, S_R_RD, S_R_WR, S_P_RD, S_P_CMP,
        S_U_RD, S_U_WR, S_T_HEAD, S_T_CMP, S_FIN_RD, S_FIN_OUT
    } t_state;

    logic [TIME_BITS-1:0]        m_dl   [MAX_TASKS];
    logic [sdtq_pkg::TASK_W-1:0] m_task [MAX_TASKS];

    t_state                      r_state;
    logic [CNT_W-1:0]            r_count, r_idx, r_pos;
    logic                        r_tick, r_found, r_any, r_acc;
    logic [sdtq_pkg::TASK_W-1:0] r_task;
    logic [TIME_BITS-1:0]        r_dl, r_now;
    logic [TIME_BITS-1:0]        r_rd_dl;
    logic [sdtq_pkg::TASK_W-1:0] r_rd_task;
    logic                        r_out_valid;
    sdtq_pkg::t_result           r_out;

    logic [AW-1:0]               w_raddr, w_waddr;
    logic                        w_we;
    logic [TIME_BITS-1:0]        w_wdl;
    logic [sdtq_pkg::TASK_W-1:0] w_wtask;
    logic [CNT_W-1:0]            w_idx_inc, w_idx_dec;
    logic [TIME_BITS-1:0]        w_d_new, w_d_now;
    logic                        w_load_ok;
    logic                        w_out_load;
    logic [sdtq_pkg::WAKE_W-1:0] w_nw;

    assign w_idx_inc = r_idx + 1'b1;
    assign w_idx_dec = r_idx - 1'b1;
    assign w_d_new   = r_dl - r_rd_dl;
    assign w_d_now   = r_now - r_rd_dl;
    assign w_load_ok = !r_out_valid || i_ready;
    // An expiry or a final result is loaded into the output register.
    assign w_out_load = w_load_ok &&
                        (((r_state == S_T_CMP) && !w_d_now[TIME_BITS-1]) ||
                         (r_state == S_FIN_OUT));
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    generate
        if (TIME_BITS >= sdtq_pkg::WAKE_W) begin : g_nw_cut
            assign w_nw = r_rd_dl[sdtq_pkg::WAKE_W-1:0];
        end else begin : g_nw_pad
            assign w_nw = {{(sdtq_pkg::WAKE_W-TIME_BITS){1'b0}}, r_rd_dl};
        end
    endgenerate

    always_comb begin
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdl   = r_rd_dl;
        w_wtask = r_rd_task;
        case (r_state)
            S_F_RD, S_P_RD: w_raddr = r_idx[AW-1:0];
            S_R_RD:         w_raddr = w_idx_inc[AW-1:0];
            S_R_WR, S_U_WR: w_we = 1'b1;
            S_U_RD: begin
                if (r_idx > r_pos) begin
                    w_raddr = w_idx_dec[AW-1:0];
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_pos[AW-1:0];
                    w_wdl   = r_dl;
                    w_wtask = r_task;
                end
            end
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_dl[w_waddr]   <= w_wdl;
            m_task[w_waddr] <= w_wtask;
        end
        r_rd_dl   <= m_dl[w_raddr];
        r_rd_task <= m_task[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load)   r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_tick  <= i_tick;
                        r_task  <= i_task;
                        r_dl    <= i_deadline;
                        r_now   <= i_now;
                        r_any   <= 1'b0;
                        r_found <= 1'b0;
                        r_acc   <= 1'b0;
                        r_idx   <= '0;
                        if (i_tick)        r_state <= S_T_HEAD;
                        else if (i_reject) r_state <= S_FIN_RD;
                        else               r_state <= S_F_RD;
                    end
                end
                S_F_RD: r_state <= (r_idx >= r_count) ? S_CHK : S_F_CMP;
                S_F_CMP: begin
                    if (r_rd_task == r_task) begin
                        r_found <= 1'b1;
                        r_state <= S_CHK;
                    end else begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_F_RD;
                    end
                end
                S_CHK: begin
                    if ((r_count == CNT_W'(MAX_TASKS)) && !r_found) begin
                        r_state <= S_FIN_RD;
                    end else if (r_found) begin
                        r_state <= S_R_RD;
                    end else begin
                        r_idx   <= '0;
                        r_state <= S_P_RD;
                    end
                end
                S_R_RD: begin
                    if (w_idx_inc < r_count) begin
                        r_state <= S_R_WR;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_idx   <= '0;
                        r_state <= r_tick ? S_T_HEAD : S_P_RD;
                    end
                end
                S_R_WR: begin
                    r_idx   <= w_idx_inc;
                    r_state <= S_R_RD;
                end
                S_P_RD: begin
                    if (r_idx >= r_count) begin
                        r_pos   <= r_count;
                        r_idx   <= r_count;
                        r_state <= S_U_RD;
                    end else begin
                        r_state <= S_P_CMP;
                    end
                end
                S_P_CMP: begin
                    if (w_d_new[TIME_BITS-1]) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_count;
                        r_state <= S_U_RD;
                    end else begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_P_RD;
                    end
                end
                S_U_RD: begin
                    if (r_idx > r_pos) begin
                        r_state <= S_U_WR;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_acc   <= 1'b1;
                        r_state <= S_FIN_RD;
                    end
                end
                S_U_WR: begin
                    r_idx   <= w_idx_dec;
                    r_state <= S_U_RD;
                end
                S_T_HEAD: r_state <= (r_count == '0) ? S_FIN_RD : S_T_CMP;
                S_T_CMP: begin
                    if (w_d_now[TIME_BITS-1]) begin
                        r_state <= S_FIN_RD;
                    end else if (w_load_ok) begin
                        r_out       <= '{accepted: 1'b0, expired_valid: 1'b1,
                                         expired_task: r_rd_task, reschedule: 1'b0,
                                         wake_armed: 1'b0, next_wake: '0, last: 1'b0};
                        r_any       <= 1'b1;
                        r_idx       <= '0;
                        r_state     <= S_R_RD;
                    end
                end
                S_FIN_RD: r_state <= S_FIN_OUT;
                S_FIN_OUT: begin
                    if (w_load_ok) begin
                        r_out       <= '{accepted: r_acc, expired_valid: 1'b0,
                                         expired_task: '0, reschedule: r_any,
                                         wake_armed: (r_count != '0),
                                         next_wake: (r_count != '0) ? w_nw : '0,
                                         last: 1'b1};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/sorted_deadline_timeout_queue_unit.sv
// Top level of the sorted deadline timeout queue: stream ports, front and back ends.
`timescale 1ns / 1ps
// This block keeps up to MAX_TASKS task deadlines sorted in wrapping time
// order in a memory with one read and one write address. A set transfer
// queues a task deadline that lies strictly after the current time,
// replacing an earlier entry of the same task, and gives one result. A tick
// transfer gives one result for each queued task whose deadline has been
// reached, then a final result with the reschedule flag and the next wake
// deadline. Each input item is taken into a two-entry front queue, so the
// next item is accepted while a result still waits. The back end walks the
// memory one entry per step, each step a registered read followed by a
// compare or a write: a set looks for the task, closes the gap of a replaced
// entry, then finds its place and opens it; a tick, for each expired task,
// pulls the remaining entries forward.
module sorted_deadline_timeout_queue_unit #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // task_id [3:0], deadline, current_time, zero fill to whole bytes
    input  logic [((sdtq_pkg::TASK_W+2*TIME_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // action
    input  logic i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // accepted, expired_task[3:0], reschedule, wake_armed, next_wake[31:0], zero
    output logic [sdtq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // expired_valid
    output logic o_m_axis_tuser,
    output logic o_m_axis_tlast
);

    localparam int DL_LO  = sdtq_pkg::TASK_W;
    localparam int NOW_LO = sdtq_pkg::TASK_W + TIME_BITS;

    logic                        w_q_valid, w_q_ready, w_q_tick, w_q_reject;
    logic [sdtq_pkg::TASK_W-1:0] w_q_task;
    logic [TIME_BITS-1:0]        w_q_dl, w_q_now;
    sdtq_pkg::t_result           w_res;

    // The front end classifies each transfer and flags sets whose deadline
    // has already been reached, so the back end can answer them at once.
    sdtq_front #(.TIME_BITS(TIME_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_action   (i_s_axis_tuser),
        .i_task     (i_s_axis_tdata[sdtq_pkg::TASK_W-1:0]),
        .i_deadline (i_s_axis_tdata[DL_LO+TIME_BITS-1:DL_LO]),
        .i_now      (i_s_axis_tdata[NOW_LO+TIME_BITS-1:NOW_LO]),
        .o_valid    (w_q_valid),
        .i_ready    (w_q_ready),
        .o_tick     (w_q_tick),
        .o_reject   (w_q_reject),
        .o_task     (w_q_task),
        .o_deadline (w_q_dl),
        .o_now      (w_q_now)
    );

    // The back end owns the sorted memory and the output register.
    sdtq_back #(.MAX_TASKS(MAX_TASKS), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_tick     (w_q_tick),
        .i_reject   (w_q_reject),
        .i_task     (w_q_task),
        .i_deadline (w_q_dl),
        .i_now      (w_q_now),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_result   (w_res)
    );

    assign o_m_axis_tdata = {1'b0, w_res.next_wake, w_res.wake_armed, w_res.reschedule,
                             w_res.expired_task, w_res.accepted};
    assign o_m_axis_tuser = w_res.expired_valid;
    assign o_m_axis_tlast = w_res.last;

endmodule

>>> sv/sdtq_checker.sv
// Port-level checker of the sorted deadline timeout queue and its bind.
`timescale 1ns / 1ps
`include "sorted_deadline_timeout_queue_unit_defines.svh"
module sdtq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [sdtq_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input logic                            i_m_tuser,
    input logic                            i_m_tlast
);

    `SDTQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast), "stalled result changed")
    `SDTQ_ASSERT_IMP(a_mid_is_expired, i_clk, i_rst_n, i_m_tvalid && !i_m_tlast, i_m_tuser, "non-final result is not an expiry")
    `SDTQ_ASSERT_IMP(a_expired_clean, i_clk, i_rst_n, i_m_tvalid && i_m_tuser, !i_m_tlast && !i_m_tdata[0] && !i_m_tdata[5] && !i_m_tdata[6], "expiry result carries final fields")
    `SDTQ_ASSERT_IMP(a_idle_wake_zero, i_clk, i_rst_n, i_m_tvalid && i_m_tlast && !i_m_tdata[6], i_m_tdata[38:7] == 32'd0, "wake time given while idle")

endmodule

bind sorted_deadline_timeout_queue_unit sdtq_checker u_sdtq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser),
    .i_m_tlast  (o_m_axis_tlast)
);
